[hdl/svpwm_pkg.sv]
// Shared types, constants and helpers for the SVPWM duty calculator.
`timescale 1ns / 1ps
package svpwm_pkg;

	localparam int unsigned QBITS = 16;      // quotient bits of one time
	localparam int unsigned NUMW  = 46;      // widest divide numerator
	localparam int unsigned DENW  = 32;      // widest divide denominator

	localparam logic [15:0]        Q15_ONE   = 16'd32768;
	localparam logic [15:0]        Q15_HALF  = 16'd16384;
	localparam logic signed [16:0] SIN60_Q15 = 17'sd28378;

	localparam logic [2:0] SECTOR_NONE = 3'd0;
	localparam logic [2:0] SECTOR_1    = 3'd1;
	localparam logic [2:0] SECTOR_2    = 3'd2;
	localparam logic [2:0] SECTOR_3    = 3'd3;
	localparam logic [2:0] SECTOR_4    = 3'd4;
	localparam logic [2:0] SECTOR_5    = 3'd5;
	localparam logic [2:0] SECTOR_6    = 3'd6;

	// One long-division lane: partial remainder, numerator bits still to
	// shift in (MSB first), quotient built so far.
	typedef struct packed {
		logic [DENW-1:0]  r;
		logic [QBITS-1:0] nb;
		logic [QBITS-1:0] q;
	} div_lane_t;

	// Everything a divide stage hands to the next one.
	typedef struct packed {
		logic            valid;
		logic [2:0]      sector;
		logic [DENW-1:0] d;
		div_lane_t       l1;
		div_lane_t       l2;
	} div_stage_t;

	// Sign code {Y<0, Z<0, X>0} to angular sector.
	function automatic logic [2:0] code_to_sector(input logic [2:0] code);
		logic [2:0] s;
		unique case (code)
			3'd1: s = SECTOR_2;
			3'd2: s = SECTOR_6;
			3'd3: s = SECTOR_1;
			3'd4: s = SECTOR_4;
			3'd5: s = SECTOR_3;
			3'd6: s = SECTOR_5;
			default: s = SECTOR_NONE;
		endcase
		return s;
	endfunction

	// Upper clamp of a nonnegative duty to one.
	function automatic logic [15:0] sat_duty(input logic [17:0] v);
		logic [15:0] r;
		if (v > {2'b00, Q15_ONE}) begin
			r = Q15_ONE;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

endpackage

[hdl/svpwm_front.sv]
// Front stages: X/Y/Z terms, sector decode and divide operand setup.
`timescale 1ns / 1ps
module svpwm_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    in_take,
	input  logic signed [15:0]      volt_alpha,
	input  logic signed [15:0]      volt_beta,
	input  logic [15:0]             bus_voltage,
	output svpwm_pkg::div_stage_t   st_out
);

	logic signed [32:0] prod;
	logic signed [31:0] bhalf;
	logic signed [31:0] nx_c, ny_c, nz_c;

	logic               valid_s1;
	logic signed [31:0] nx_s1, ny_s1, nz_s1;
	logic [15:0]        vdc_s1;

	logic [2:0]         sec;
	logic signed [31:0] n1, n2;
	logic [30:0]        n1c, n2c;
	logic [31:0]        sum;
	logic               ovm;
	logic [svpwm_pkg::NUMW-1:0] num1, num2;
	logic [31:0]        den;

	svpwm_pkg::div_stage_t st_s2;

	// stage 1: terms scaled by 32768
	assign prod  = svpwm_pkg::SIN60_Q15 * volt_alpha;
	assign bhalf = $signed({{2{volt_beta[15]}}, volt_beta, 14'b0});
	assign nx_c  = $signed({volt_beta[15], volt_beta, 15'b0});
	assign ny_c  = prod[31:0] + bhalf;
	assign nz_c  = bhalf - prod[31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_take;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nx_s1  <= nx_c;
			ny_s1  <= ny_c;
			nz_s1  <= nz_c;
			vdc_s1 <= (bus_voltage == 16'd0) ? 16'd1 : bus_voltage;
		end
	end

	// stage 2: pick active times, detect overmodulation
	assign sec = svpwm_pkg::code_to_sector({ny_s1 < 0, nz_s1 < 0, nx_s1 > 0});

	always_comb begin
		unique case (sec)
			svpwm_pkg::SECTOR_1: begin n1 = -nz_s1; n2 = nx_s1;  end
			svpwm_pkg::SECTOR_2: begin n1 = nz_s1;  n2 = ny_s1;  end
			svpwm_pkg::SECTOR_3: begin n1 = nx_s1;  n2 = -ny_s1; end
			svpwm_pkg::SECTOR_4: begin n1 = -nx_s1; n2 = nz_s1;  end
			svpwm_pkg::SECTOR_5: begin n1 = -ny_s1; n2 = -nz_s1; end
			svpwm_pkg::SECTOR_6: begin n1 = ny_s1;  n2 = -nx_s1; end
			default:             begin n1 = '0;     n2 = '0;     end
		endcase
	end

	assign n1c  = n1[31] ? 31'd0 : n1[30:0];
	assign n2c  = n2[31] ? 31'd0 : n2[30:0];
	assign sum  = {1'b0, n1c} + {1'b0, n2c};
	assign ovm  = sum > {1'b0, vdc_s1, 15'b0};
	assign num1 = ovm ? {n1c, 15'b0} : {15'b0, n1c};
	assign num2 = ovm ? {n2c, 15'b0} : {15'b0, n2c};
	assign den  = ovm ? sum : {16'b0, vdc_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_s2 <= '0;
		end else if (en) begin
			st_s2.valid  <= valid_s1;
			st_s2.sector <= sec;
			st_s2.d      <= den;
			st_s2.l1.r   <= {2'b00, num1[45:16]};
			st_s2.l1.nb  <= num1[15:0];
			st_s2.l1.q   <= '0;
			st_s2.l2.r   <= {2'b00, num2[45:16]};
			st_s2.l2.nb  <= num2[15:0];
			st_s2.l2.q   <= '0;
		end
	end

	assign st_out = st_s2;

endmodule

[hdl/svpwm_div_stage.sv]
// One restoring-division step for both active times, registered.
`timescale 1ns / 1ps
module svpwm_div_stage (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  svpwm_pkg::div_stage_t st_in,
	output svpwm_pkg::div_stage_t st_out
);

	logic [32:0] t1, t2, df1, df2;
	logic        ge1, ge2;
	svpwm_pkg::div_stage_t st_q;

	assign t1  = {st_in.l1.r, st_in.l1.nb[15]};
	assign t2  = {st_in.l2.r, st_in.l2.nb[15]};
	assign ge1 = t1 >= {1'b0, st_in.d};
	assign ge2 = t2 >= {1'b0, st_in.d};
	assign df1 = t1 - {1'b0, st_in.d};
	assign df2 = t2 - {1'b0, st_in.d};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (en) begin
			st_q.valid  <= st_in.valid;
			st_q.sector <= st_in.sector;
			st_q.d      <= st_in.d;
			st_q.l1.r   <= ge1 ? df1[31:0] : t1[31:0];
			st_q.l1.nb  <= {st_in.l1.nb[14:0], 1'b0};
			st_q.l1.q   <= {st_in.l1.q[14:0], ge1};
			st_q.l2.r   <= ge2 ? df2[31:0] : t2[31:0];
			st_q.l2.nb  <= {st_in.l2.nb[14:0], 1'b0};
			st_q.l2.q   <= {st_in.l2.q[14:0], ge2};
		end
	end

	assign st_out = st_q;

endmodule

[hdl/svpwm_out.sv]
// Output stage: zero time split and seven-segment duties per sector.
`timescale 1ns / 1ps
module svpwm_out (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  svpwm_pkg::div_stage_t st_in,
	output logic                  valid,
	output logic [2:0]            sector,
	output logic [15:0]           da,
	output logic [15:0]           db,
	output logic [15:0]           dc
);

	logic [15:0]        t1, t2;
	logic signed [17:0] t0;
	logic [15:0]        h;
	logic [17:0]        h0, h1, h2, h12;
	logic [15:0]        a_c, b_c, c_c;

	assign t1  = st_in.l1.q;
	assign t2  = st_in.l2.q;
	assign t0  = $signed({2'b00, svpwm_pkg::Q15_ONE}) - $signed({2'b00, t1})
	           - $signed({2'b00, t2});
	assign h   = t0[17] ? 16'd0 : t0[16:1];
	assign h0  = {2'b00, h};
	assign h1  = h0 + {2'b00, t1};
	assign h2  = h0 + {2'b00, t2};
	assign h12 = h1 + {2'b00, t2};

	always_comb begin
		unique case (st_in.sector)
			svpwm_pkg::SECTOR_1: begin
				a_c = svpwm_pkg::sat_duty(h0);
				b_c = svpwm_pkg::sat_duty(h1);
				c_c = svpwm_pkg::sat_duty(h12);
			end
			svpwm_pkg::SECTOR_2: begin
				a_c = svpwm_pkg::sat_duty(h2);
				b_c = svpwm_pkg::sat_duty(h0);
				c_c = svpwm_pkg::sat_duty(h12);
			end
			svpwm_pkg::SECTOR_3: begin
				a_c = svpwm_pkg::sat_duty(h12);
				b_c = svpwm_pkg::sat_duty(h0);
				c_c = svpwm_pkg::sat_duty(h1);
			end
			svpwm_pkg::SECTOR_4: begin
				a_c = svpwm_pkg::sat_duty(h12);
				b_c = svpwm_pkg::sat_duty(h2);
				c_c = svpwm_pkg::sat_duty(h0);
			end
			svpwm_pkg::SECTOR_5: begin
				a_c = svpwm_pkg::sat_duty(h1);
				b_c = svpwm_pkg::sat_duty(h12);
				c_c = svpwm_pkg::sat_duty(h0);
			end
			svpwm_pkg::SECTOR_6: begin
				a_c = svpwm_pkg::sat_duty(h0);
				b_c = svpwm_pkg::sat_duty(h12);
				c_c = svpwm_pkg::sat_duty(h2);
			end
			default: begin
				a_c = svpwm_pkg::Q15_HALF;
				b_c = svpwm_pkg::Q15_HALF;
				c_c = svpwm_pkg::Q15_HALF;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid <= 1'b0;
		end else if (en) begin
			valid <= st_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sector <= st_in.sector;
			da     <= a_c;
			db     <= b_c;
			dc     <= c_c;
		end
	end

endmodule

[hdl/svpwm_duty_calculator.sv]
// Top level of the seven-segment space vector PWM duty calculator.
`timescale 1ns / 1ps
// Seven-segment SVPWM duty calculator. Each request carries an alpha/beta
// voltage reference and the DC bus voltage (0 is taken as 1); the result
// carries the angular sector (1..6, 0 for a zero reference) and the phase
// a/b/c duties in Q1.15, 32768 meaning a full period. The duties are the
// complements of the usual high-side duties, and no sqrt(3) gain is applied.
// When the two active times add up to more than one period, both are scaled
// back by their sum (overmodulation). The block is a 19-stage pipeline:
// two stages form the X/Y/Z terms and the divide operands, sixteen stages
// run a one-bit-per-stage restoring divider for both active times, and one
// stage builds the duties into the output register. A new request is taken
// every cycle while in_stall is low. out_stall freezes the whole pipe, so
// in_stall follows out_stall while a result is waiting at the output.
module svpwm_duty_calculator (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] volt_alpha,
	input  logic signed [15:0] volt_beta,
	input  logic [15:0]        bus_voltage,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [2:0]         sector_number,
	output logic [15:0]        duty_a,
	output logic [15:0]        duty_b,
	output logic [15:0]        duty_c
);

	// pipe advances unless a finished result is held at the output
	logic en;
	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	svpwm_pkg::div_stage_t st [0:svpwm_pkg::QBITS];

	svpwm_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.in_take     (in_valid),
		.volt_alpha  (volt_alpha),
		.volt_beta   (volt_beta),
		.bus_voltage (bus_voltage),
		.st_out      (st[0])
	);

	// one quotient bit per stage, MSB first
	for (genvar i = 0; i < svpwm_pkg::QBITS; i++) begin : g_div
		svpwm_div_stage u_div (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.st_in  (st[i]),
			.st_out (st[i+1])
		);
	end

	svpwm_out u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.st_in  (st[svpwm_pkg::QBITS]),
		.valid  (out_valid),
		.sector (sector_number),
		.da     (duty_a),
		.db     (duty_b),
		.dc     (duty_c)
	);

	a_sector_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> sector_number <= svpwm_pkg::SECTOR_6)
		else $error("sector out of range");

	a_none_half: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && sector_number == svpwm_pkg::SECTOR_NONE |->
		duty_a == svpwm_pkg::Q15_HALF && duty_b == svpwm_pkg::Q15_HALF &&
		duty_c == svpwm_pkg::Q15_HALF)
		else $error("undetermined sector without half duties");

	a_duty_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> duty_a <= svpwm_pkg::Q15_ONE && duty_b <= svpwm_pkg::Q15_ONE &&
		duty_c <= svpwm_pkg::Q15_ONE)
		else $error("duty above one");

endmodule
